/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/tmlo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmlo_pkg
// types, widths, format table and level helpers of the mip layout pipeline
// ----------------------------------------------------------------------------
package tmlo_pkg;

   localparam int MAX_DIM_LOG2     = 14;
   localparam int FORMAT_COUNT     = 102;
   localparam int DEF_SLICE_BITS   = 11;

   localparam int FMT_W    = 7;
   localparam int LVL_W    = 4;
   localparam int SIZE_W   = 5;
   localparam int STATUS_W = 2;
   localparam int DIM_W    = MAX_DIM_LOG2 + 1;
   localparam int LEVELS   = MAX_DIM_LOG2 + 1;
   localparam int PITCH_W  = MAX_DIM_LOG2 + 5;
   localparam int LPITCH_W = 2 * MAX_DIM_LOG2 + 5;
   localparam int GRP      = 4;
   localparam int NGRP     = (LEVELS + GRP - 1) / GRP;
   localparam int NSTG     = 6;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_BAD_FORMAT = 2'd1,
      ST_BAD_LEVEL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic              bc;
   } fmt_type;

   typedef struct packed {
      status_type        status;
      logic [SIZE_W-1:0] size;
      logic              bc;
      logic [LVL_W-1:0]  lw;
      logic [LVL_W-1:0]  lh;
      logic [LVL_W-1:0]  lvl;
      logic [LVL_W-1:0]  chain;
      logic [LVL_W-1:0]  count;
   } dec_type;

   typedef struct packed {
      status_type                       status;
      logic [LVL_W-1:0]                 chain;
      logic [LEVELS-1:0][LPITCH_W-1:0]  lp;
      logic [LEVELS-1:0]                mask_full;
      logic [LEVELS-1:0]                mask_part;
      logic [LEVELS-1:0]                mask_loff;
      logic [PITCH_W-1:0]               row_pitch;
      logic [DIM_W-1:0]                 row_count;
      logic [LPITCH_W-1:0]              level_pitch;
   } lane_type;

   typedef struct packed {
      status_type                     status;
      logic [LVL_W-1:0]               chain;
      logic [NGRP-1:0][LPITCH_W-1:0]  g_full;
      logic [NGRP-1:0][LPITCH_W-1:0]  g_part;
      logic [NGRP-1:0][LPITCH_W-1:0]  g_loff;
      logic [PITCH_W-1:0]             row_pitch;
      logic [DIM_W-1:0]               row_count;
      logic [LPITCH_W-1:0]            level_pitch;
   } grp_type;

   typedef struct packed {
      status_type           status;
      logic [LVL_W-1:0]     chain;
      logic [LPITCH_W-1:0]  full;
      logic [LPITCH_W-1:0]  part;
      logic [LPITCH_W-1:0]  loff;
      logic [PITCH_W-1:0]   row_pitch;
      logic [DIM_W-1:0]     row_count;
      logic [LPITCH_W-1:0]  level_pitch;
   } tot_type;

   typedef struct packed {
      status_type           status;
      logic [LVL_W-1:0]     chain;
      logic [LPITCH_W-1:0]  part;
      logic [LPITCH_W-1:0]  loff;
      logic [PITCH_W-1:0]   row_pitch;
      logic [DIM_W-1:0]     row_count;
      logic [LPITCH_W-1:0]  level_pitch;
   } res_type;

   // element bytes and block-compressed flag per format
   function automatic fmt_type fmt_lookup(input logic [FMT_W-1:0] code);
      fmt_type r;
      r.size = '0;
      r.bc   = 1'b0;
      if (code == 7'd0) begin
         r.size = 5'd0;
      end else if (code < 7'd5) begin
         r.size = 5'd16;
      end else if (code < 7'd9) begin
         r.size = 5'd12;
      end else if (code < 7'd23) begin
         r.size = 5'd8;
      end else if (code < 7'd48) begin
         r.size = 5'd4;
      end else if (code < 7'd60) begin
         r.size = 5'd2;
      end else if (code < 7'd67) begin
         r.size = 5'd1;
      end else if (code < 7'd70) begin
         r.size = 5'd4;
      end else if (code < 7'd73) begin
         r.size = 5'd8;
         r.bc   = 1'b1;
      end else if (code < 7'd79) begin
         r.size = 5'd16;
         r.bc   = 1'b1;
      end else if (code < 7'd82) begin
         r.size = 5'd8;
         r.bc   = 1'b1;
      end else if (code < 7'd85) begin
         r.size = 5'd16;
         r.bc   = 1'b1;
      end else if (code < 7'd87) begin
         r.size = 5'd2;
      end else if (code < 7'd94) begin
         r.size = 5'd4;
      end else if (code < 7'd100) begin
         r.size = 5'd16;
         r.bc   = 1'b1;
      end else begin
         r.size = 5'd3;
      end
      return r;
   endfunction

   // bit index of a one-hot dimension
   function automatic logic [LVL_W-1:0] dim_log(input logic [DIM_W-1:0] v);
      logic [LVL_W-1:0] r;
      r = '0;
      for (int i = 0; i < DIM_W; i++) begin
         if (v[i]) begin
            r = LVL_W'(i);
         end
      end
      return r;
   endfunction

   // log2 of elements or blocks along one axis at a level
   function automatic logic [LVL_W-1:0] level_log(input logic [LVL_W-1:0] base_log,
                                                  input logic [LVL_W-1:0] level,
                                                  input logic             bc);
      logic [LVL_W+1:0] drop;
      logic [LVL_W+1:0] base;
      logic [LVL_W+1:0] diff;
      drop = {2'b00, level} + (bc ? (LVL_W+2)'(2) : (LVL_W+2)'(0));
      base = {2'b00, base_log};
      diff = base - drop;
      return (base >= drop) ? diff[LVL_W-1:0] : '0;
   endfunction

   // bytes per row, four-byte aligned
   function automatic logic [PITCH_W-1:0] row_bytes(input logic [SIZE_W-1:0] size,
                                                    input logic [LVL_W-1:0]  elog);
      logic [PITCH_W-1:0] raw;
      logic [PITCH_W-1:0] sum;
      raw = PITCH_W'(size) << elog;
      sum = raw + PITCH_W'(3);
      return {sum[PITCH_W-1:2], 2'b00};
   endfunction

endpackage

/* sv/tmlo_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmlo_decode
// first stage: format lookup, base checks, chain length and status
// ----------------------------------------------------------------------------
module tmlo_decode (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [tmlo_pkg::FMT_W-1:0]    format_code,
   input  logic [tmlo_pkg::DIM_W-1:0]    base_width,
   input  logic [tmlo_pkg::DIM_W-1:0]    base_height,
   input  logic [tmlo_pkg::LVL_W-1:0]    mip_level,
   input  logic [tmlo_pkg::LVL_W-1:0]    mip_count_override,
   output tmlo_pkg::dec_type             dec
);
   import tmlo_pkg::*;

   dec_type          dec_in;
   dec_type          dec_ff;
   fmt_type          fmt;
   logic [LVL_W-1:0] lw;
   logic [LVL_W-1:0] lh;
   logic [LVL_W-1:0] chain;

   always_comb begin
      fmt   = fmt_lookup(format_code);
      lw    = dim_log(base_width);
      lh    = dim_log(base_height);
      chain = ((lw > lh) ? lw : lh) + LVL_W'(1);

      dec_in.size  = fmt.size;
      dec_in.bc    = fmt.bc;
      dec_in.lw    = lw;
      dec_in.lh    = lh;
      dec_in.lvl   = mip_level;
      dec_in.chain = chain;
      dec_in.count = (mip_count_override == '0) ? chain : mip_count_override;

      if (format_code == '0 || format_code >= FMT_W'(FORMAT_COUNT)) begin
         dec_in.status = ST_BAD_FORMAT;
      end else if (!$onehot(base_width) || !$onehot(base_height) ||
                   mip_level >= chain) begin
         dec_in.status = ST_BAD_LEVEL;
      end else begin
         dec_in.status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dec_ff <= dec_in;
      end
   end

   assign dec = dec_ff;

endmodule

/* sv/tmlo_lanes.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmlo_lanes
// second stage: one lane per mip level giving its level pitch, plus masks
// ----------------------------------------------------------------------------
module tmlo_lanes (
   input  logic               clock,
   input  logic               enable,
   input  tmlo_pkg::dec_type  dec,
   output tmlo_pkg::lane_type lane
);
   import tmlo_pkg::*;

   lane_type           lane_in;
   lane_type           lane_ff;
   logic [LVL_W-1:0]   elog [LEVELS];
   logic [LVL_W-1:0]   rlog [LEVELS];
   logic [PITCH_W-1:0] pitch [LEVELS];
   logic [LVL_W-1:0]   sel_elog;
   logic [LVL_W-1:0]   sel_rlog;
   logic [PITCH_W-1:0] sel_pitch;

   always_comb begin
      lane_in.status = dec.status;
      lane_in.chain  = dec.chain;
      for (int i = 0; i < LEVELS; i++) begin
         elog[i]  = level_log(dec.lw, LVL_W'(i), dec.bc);
         rlog[i]  = level_log(dec.lh, LVL_W'(i), dec.bc);
         pitch[i] = row_bytes(dec.size, elog[i]);
         lane_in.lp[i]        = LPITCH_W'(pitch[i]) << rlog[i];
         lane_in.mask_full[i] = LVL_W'(i) < dec.chain;
         lane_in.mask_part[i] = LVL_W'(i) < dec.count;
         lane_in.mask_loff[i] = LVL_W'(i) < dec.lvl;
      end

      // requested level
      sel_elog  = level_log(dec.lw, dec.lvl, dec.bc);
      sel_rlog  = level_log(dec.lh, dec.lvl, dec.bc);
      sel_pitch = row_bytes(dec.size, sel_elog);
      lane_in.row_pitch   = sel_pitch;
      lane_in.row_count   = DIM_W'(1) << sel_rlog;
      lane_in.level_pitch = LPITCH_W'(sel_pitch) << sel_rlog;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in;
      end
   end

   assign lane = lane_ff;

endmodule

/* sv/tmlo_sum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmlo_sum
// third and fourth stages: masked level pitches summed in a registered tree
// ----------------------------------------------------------------------------
module tmlo_sum (
   input  logic               clock,
   input  logic               enable_grp,
   input  logic               enable_tot,
   input  tmlo_pkg::lane_type lane,
   output tmlo_pkg::tot_type  tot
);
   import tmlo_pkg::*;

   grp_type grp_in;
   grp_type grp_ff;
   tot_type tot_in;
   tot_type tot_ff;

   // group sums of up to four lanes
   always_comb begin
      grp_in.status      = lane.status;
      grp_in.chain       = lane.chain;
      grp_in.row_pitch   = lane.row_pitch;
      grp_in.row_count   = lane.row_count;
      grp_in.level_pitch = lane.level_pitch;
      for (int g = 0; g < NGRP; g++) begin
         grp_in.g_full[g] = '0;
         grp_in.g_part[g] = '0;
         grp_in.g_loff[g] = '0;
         for (int j = 0; j < GRP; j++) begin
            if (g * GRP + j < LEVELS) begin
               grp_in.g_full[g] = grp_in.g_full[g] +
                  (lane.lp[g*GRP+j] & {LPITCH_W{lane.mask_full[g*GRP+j]}});
               grp_in.g_part[g] = grp_in.g_part[g] +
                  (lane.lp[g*GRP+j] & {LPITCH_W{lane.mask_part[g*GRP+j]}});
               grp_in.g_loff[g] = grp_in.g_loff[g] +
                  (lane.lp[g*GRP+j] & {LPITCH_W{lane.mask_loff[g*GRP+j]}});
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable_grp) begin
         grp_ff <= grp_in;
      end
   end

   // totals over the groups
   always_comb begin
      tot_in.status      = grp_ff.status;
      tot_in.chain       = grp_ff.chain;
      tot_in.row_pitch   = grp_ff.row_pitch;
      tot_in.row_count   = grp_ff.row_count;
      tot_in.level_pitch = grp_ff.level_pitch;
      tot_in.full        = '0;
      tot_in.part        = '0;
      tot_in.loff        = '0;
      for (int g = 0; g < NGRP; g++) begin
         tot_in.full = tot_in.full + grp_ff.g_full[g];
         tot_in.part = tot_in.part + grp_ff.g_part[g];
         tot_in.loff = tot_in.loff + grp_ff.g_loff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (enable_tot) begin
         tot_ff <= tot_in;
      end
   end

   assign tot = tot_ff;

endmodule

/* sv/tmlo_offset.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmlo_offset
// fifth and sixth stages: slice times full chain pitch, level offset added, output
// ----------------------------------------------------------------------------
module tmlo_offset #(
   parameter int SLICE_BITS = tmlo_pkg::DEF_SLICE_BITS
) (
   input  logic                                     clock,
   input  logic                                     enable_mul,
   input  logic                                     enable_out,
   input  tmlo_pkg::tot_type                        tot,
   input  logic [SLICE_BITS-1:0]                    slice,
   output tmlo_pkg::res_type                        res,
   output logic [tmlo_pkg::LPITCH_W+SLICE_BITS-1:0] buffer_offset
);
   import tmlo_pkg::*;

   localparam int OFF_W = LPITCH_W + SLICE_BITS;

   res_type           mul_in;
   res_type           mul_ff;
   logic [OFF_W-1:0]  prod_in;
   logic [OFF_W-1:0]  prod_ff;
   res_type           res_in;
   res_type           res_ff;
   logic [OFF_W-1:0]  boff_in;
   logic [OFF_W-1:0]  boff_ff;

   always_comb begin
      mul_in.status      = tot.status;
      mul_in.chain       = tot.chain;
      mul_in.part        = tot.part;
      mul_in.loff        = tot.loff;
      mul_in.row_pitch   = tot.row_pitch;
      mul_in.row_count   = tot.row_count;
      mul_in.level_pitch = tot.level_pitch;
      prod_in            = OFF_W'(slice) * OFF_W'(tot.full);
   end

   always_ff @(posedge clock) begin
      if (enable_mul) begin
         mul_ff  <= mul_in;
         prod_ff <= prod_in;
      end
   end

   // errors report status alone
   always_comb begin
      if (mul_ff.status == ST_OK) begin
         res_in  = mul_ff;
         boff_in = prod_ff + OFF_W'(mul_ff.loff);
      end else begin
         res_in        = '0;
         res_in.status = mul_ff.status;
         boff_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable_out) begin
         res_ff  <= res_in;
         boff_ff <= boff_in;
      end
   end

   assign res           = res_ff;
   assign buffer_offset = boff_ff;

endmodule

/* sv/texture_mip_layout_offset.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// texture_mip_layout_offset
// mip chain layout: pitches, level offset, slice pitch and buffer offset
// ----------------------------------------------------------------------------
// usage
//   req_ channel carries one texture request per beat: format code, power of
//   two base width and height, mip level, array slice and mip count override
//   rsp_ channel returns one beat per request, in order: row pitch, row
//   count, level pitch, level offset, slice pitch, chain length, buffer
//   offset and status; on any error status all other fields are zero
//   request beats pass through the register stages in order: decode, level
//   lanes, group sums, totals, slice multiply, offset add
//   throughput is one beat per cycle while unstalled; the per-level lanes and
//   summing tree are fully pipelined, so no stage is shared between requests
//   a stalled response holds the last stage; earlier stages keep filling
//   empty slots, and req_ready drops only once every stage holds a beat
//   reset empties the pipeline; the format table is logic and needs no fill
// ----------------------------------------------------------------------------
module texture_mip_layout_offset #(
   parameter int SLICE_BITS = tmlo_pkg::DEF_SLICE_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [tmlo_pkg::FMT_W-1:0]               req_format_code,
   input  logic [tmlo_pkg::DIM_W-1:0]               req_base_width,
   input  logic [tmlo_pkg::DIM_W-1:0]               req_base_height,
   input  logic [tmlo_pkg::LVL_W-1:0]               req_mip_level,
   input  logic [SLICE_BITS-1:0]                    req_array_slice,
   input  logic [tmlo_pkg::LVL_W-1:0]               req_mip_count_override,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [tmlo_pkg::PITCH_W-1:0]             rsp_row_pitch,
   output logic [tmlo_pkg::DIM_W-1:0]               rsp_row_count,
   output logic [tmlo_pkg::LPITCH_W-1:0]            rsp_level_pitch,
   output logic [tmlo_pkg::LPITCH_W-1:0]            rsp_level_offset,
   output logic [tmlo_pkg::LPITCH_W-1:0]            rsp_slice_pitch,
   output logic [tmlo_pkg::LVL_W-1:0]               rsp_chain_length,
   output logic [tmlo_pkg::LPITCH_W+SLICE_BITS-1:0] rsp_buffer_offset,
   output logic [tmlo_pkg::STATUS_W-1:0]            rsp_status
);
   import tmlo_pkg::*;

   logic [NSTG-1:0]       v_in;
   logic [NSTG-1:0]       v_ff;
   logic [NSTG-1:0]       adv;
   logic [SLICE_BITS-1:0] slice_ff [NSTG-2];
   dec_type               dec;
   lane_type              lane;
   tot_type               tot;
   res_type               res;

   // a stage loads when it is empty or its contents move on
   always_comb begin
      adv[NSTG-1] = !v_ff[NSTG-1] || rsp_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      v_in[0] = adv[0] ? req_valid : v_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         v_in[k] = adv[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // slice index rides alongside until the multiply
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         slice_ff[0] <= req_array_slice;
      end
      for (int k = 1; k < NSTG - 2; k++) begin
         if (adv[k]) begin
            slice_ff[k] <= slice_ff[k-1];
         end
      end
   end

   tmlo_decode u_decode (
      .clock              (clock),
      .enable             (adv[0]),
      .format_code        (req_format_code),
      .base_width         (req_base_width),
      .base_height        (req_base_height),
      .mip_level          (req_mip_level),
      .mip_count_override (req_mip_count_override),
      .dec                (dec)
   );

   tmlo_lanes u_lanes (
      .clock  (clock),
      .enable (adv[1]),
      .dec    (dec),
      .lane   (lane)
   );

   tmlo_sum u_sum (
      .clock      (clock),
      .enable_grp (adv[2]),
      .enable_tot (adv[3]),
      .lane       (lane),
      .tot        (tot)
   );

   tmlo_offset #(
      .SLICE_BITS (SLICE_BITS)
   ) u_offset (
      .clock         (clock),
      .enable_mul    (adv[4]),
      .enable_out    (adv[5]),
      .tot           (tot),
      .slice         (slice_ff[NSTG-3]),
      .res           (res),
      .buffer_offset (rsp_buffer_offset)
   );

   assign req_ready        = adv[0];
   assign rsp_valid        = v_ff[NSTG-1];
   assign rsp_row_pitch    = res.row_pitch;
   assign rsp_row_count    = res.row_count;
   assign rsp_level_pitch  = res.level_pitch;
   assign rsp_level_offset = res.loff;
   assign rsp_slice_pitch  = res.part;
   assign rsp_chain_length = res.chain;
   assign rsp_status       = res.status;

   `ASSERT_IMPLIES(a_err_zero, clock, reset,
      rsp_valid && rsp_status != ST_OK,
      rsp_row_pitch == '0 && rsp_chain_length == '0 && rsp_buffer_offset == '0,
      "error beat carries nonzero fields")
   `ASSERT_IMPLIES(a_ok_shape, clock, reset,
      rsp_valid && rsp_status == ST_OK,
      rsp_row_pitch[1:0] == 2'b00 && rsp_chain_length != '0 && rsp_row_count != '0,
      "good beat with misaligned pitch or empty chain")
   `ASSERT_IMPLIES(a_ok_offset, clock, reset,
      rsp_valid && rsp_status == ST_OK,
      rsp_buffer_offset >= (SLICE_BITS + LPITCH_W)'(rsp_level_offset),
      "buffer offset below level offset")

endmodule

/* dv/tmlo_layout_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmlo_layout_checker
// watches both channels of the mip layout block; every request beat is run
// through an independent layout calculation and queued, and every response
// beat is compared field by field with the oldest queued layout
// ----------------------------------------------------------------------------
module tmlo_layout_checker #(
   parameter int SLICE_BITS = tmlo_pkg::DEF_SLICE_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_ready,
   input  logic [tmlo_pkg::FMT_W-1:0]               req_format_code,
   input  logic [tmlo_pkg::DIM_W-1:0]               req_base_width,
   input  logic [tmlo_pkg::DIM_W-1:0]               req_base_height,
   input  logic [tmlo_pkg::LVL_W-1:0]               req_mip_level,
   input  logic [SLICE_BITS-1:0]                    req_array_slice,
   input  logic [tmlo_pkg::LVL_W-1:0]               req_mip_count_override,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   input  logic [tmlo_pkg::PITCH_W-1:0]             rsp_row_pitch,
   input  logic [tmlo_pkg::DIM_W-1:0]               rsp_row_count,
   input  logic [tmlo_pkg::LPITCH_W-1:0]            rsp_level_pitch,
   input  logic [tmlo_pkg::LPITCH_W-1:0]            rsp_level_offset,
   input  logic [tmlo_pkg::LPITCH_W-1:0]            rsp_slice_pitch,
   input  logic [tmlo_pkg::LVL_W-1:0]               rsp_chain_length,
   input  logic [tmlo_pkg::LPITCH_W+SLICE_BITS-1:0] rsp_buffer_offset,
   input  logic [tmlo_pkg::STATUS_W-1:0]            rsp_status,
   output int                                       pending_layouts,
   output int                                       mismatch_count
);
   import tmlo_pkg::*;

   localparam int BOFF_W = LPITCH_W + SLICE_BITS;

   typedef struct packed {
      logic [PITCH_W-1:0]  row_pitch;
      logic [DIM_W-1:0]    row_count;
      logic [LPITCH_W-1:0] level_pitch;
      logic [LPITCH_W-1:0] level_offset;
      logic [LPITCH_W-1:0] slice_pitch;
      logic [LVL_W-1:0]    chain_length;
      logic [BOFF_W-1:0]   buffer_offset;
      status_type          status;
   } layout_type;

   layout_type expected_layouts[$];

   function automatic logic is_pow2_dim(input logic [DIM_W-1:0] v);
      return v != '0 && (v & (v - 1'b1)) == '0 && v <= (DIM_W'(1) << MAX_DIM_LOG2);
   endfunction

   // elements (or blocks) along one axis at a level
   function automatic logic [31:0] level_extent(input logic [DIM_W-1:0] base,
                                                input int lvl, input logic bc);
      logic [31:0] v;
      v = 32'(base) >> lvl;
      if (v == 0) begin
         v = 32'd1;
      end
      if (bc) begin
         v = ((v + 32'd3) & ~32'd3) / 32'd4;
         if (v == 0) begin
            v = 32'd1;
         end
      end
      return v;
   endfunction

   function automatic layout_type predict_layout(input logic [FMT_W-1:0]  fmt,
                                                 input logic [DIM_W-1:0]  w,
                                                 input logic [DIM_W-1:0]  h,
                                                 input logic [LVL_W-1:0]  lvl,
                                                 input logic [SLICE_BITS-1:0] slice,
                                                 input logic [LVL_W-1:0]  ovr);
      layout_type  r;
      logic [4:0]  esize;
      logic        bc;
      logic [DIM_W-1:0] m;
      logic [63:0] full, part, loff, pitch, rows, lp, sel_pitch, sel_rows, boff;
      int          chain, nsum;
      r = '0;
      r.status = ST_OK;
      if (fmt == 0 || fmt >= FORMAT_COUNT) begin
         r.status = ST_BAD_FORMAT;
         return r;
      end
      if (!is_pow2_dim(w) || !is_pow2_dim(h)) begin
         r.status = ST_BAD_LEVEL;
         return r;
      end
      m = (w > h) ? w : h;
      chain = 1;
      for (int k = 1; k < DIM_W; k++) begin
         if ((m >> k) != 0) begin
            chain = k + 1;
         end
      end
      if (int'(lvl) >= chain) begin
         r.status = ST_BAD_LEVEL;
         return r;
      end
      bc = 1'b0;
      if (fmt < 5)        esize = 5'd16;
      else if (fmt < 9)   esize = 5'd12;
      else if (fmt < 23)  esize = 5'd8;
      else if (fmt < 48)  esize = 5'd4;
      else if (fmt < 60)  esize = 5'd2;
      else if (fmt < 67)  esize = 5'd1;
      else if (fmt < 70)  esize = 5'd4;
      else if (fmt < 73)  begin esize = 5'd8;  bc = 1'b1; end
      else if (fmt < 79)  begin esize = 5'd16; bc = 1'b1; end
      else if (fmt < 82)  begin esize = 5'd8;  bc = 1'b1; end
      else if (fmt < 85)  begin esize = 5'd16; bc = 1'b1; end
      else if (fmt < 87)  esize = 5'd2;
      else if (fmt < 94)  esize = 5'd4;
      else if (fmt < 100) begin esize = 5'd16; bc = 1'b1; end
      else                esize = 5'd3;
      nsum = (ovr == 0) ? chain : int'(ovr);
      full = 0;
      part = 0;
      loff = 0;
      sel_pitch = 0;
      sel_rows = 0;
      // levels past the chain count as single-element levels
      for (int i = 0; i < 16; i++) begin
         pitch = (64'(level_extent(w, i, bc)) * 64'(esize) + 64'd3) & ~64'd3;
         rows  = 64'(level_extent(h, i, bc));
         lp    = pitch * rows;
         if (i < chain) full += lp;
         if (i < nsum)  part += lp;
         if (i < int'(lvl)) loff += lp;
         if (i == int'(lvl)) begin
            sel_pitch = pitch;
            sel_rows = rows;
         end
      end
      boff = 64'(slice) * full + loff;
      lp = sel_pitch * sel_rows;
      r.row_pitch     = sel_pitch[PITCH_W-1:0];
      r.row_count     = sel_rows[DIM_W-1:0];
      r.level_pitch   = lp[LPITCH_W-1:0];
      r.level_offset  = loff[LPITCH_W-1:0];
      r.slice_pitch   = part[LPITCH_W-1:0];
      r.chain_length  = LVL_W'(chain);
      r.buffer_offset = boff[BOFF_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   initial begin
      pending_layouts = 0;
      mismatch_count = 0;
   end

   always @(posedge clock) begin
      layout_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_layouts.size() == 0) begin
               $error("rsp beat with no request outstanding");
               mismatch_count++;
            end else begin
               want = expected_layouts.pop_front();
               check_field("row_pitch",     64'(want.row_pitch),     64'(rsp_row_pitch));
               check_field("row_count",     64'(want.row_count),     64'(rsp_row_count));
               check_field("level_pitch",   64'(want.level_pitch),   64'(rsp_level_pitch));
               check_field("level_offset",  64'(want.level_offset),  64'(rsp_level_offset));
               check_field("slice_pitch",   64'(want.slice_pitch),   64'(rsp_slice_pitch));
               check_field("chain_length",  64'(want.chain_length),  64'(rsp_chain_length));
               check_field("buffer_offset", 64'(want.buffer_offset), 64'(rsp_buffer_offset));
               check_field("status",        64'(want.status),        64'(rsp_status));
            end
         end
         if (req_valid && req_ready) begin
            expected_layouts.push_back(predict_layout(req_format_code, req_base_width,
                                                      req_base_height, req_mip_level,
                                                      req_array_slice,
                                                      req_mip_count_override));
         end
         pending_layouts = expected_layouts.size();
      end
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives texture requests into the mip layout block: a directed set of edge
// cases, then bursty random requests against a stalling response side; a
// separate checker predicts and compares every response beat
// ----------------------------------------------------------------------------
module tb_top;
   import tmlo_pkg::*;

   localparam int SLICE_BITS = DEF_SLICE_BITS;
   localparam int RANDOM_REQS = 1150;
   localparam int IDLE_LIMIT = 4000;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [FMT_W-1:0]                req_format_code;
   logic [DIM_W-1:0]                req_base_width;
   logic [DIM_W-1:0]                req_base_height;
   logic [LVL_W-1:0]                req_mip_level;
   logic [SLICE_BITS-1:0]           req_array_slice;
   logic [LVL_W-1:0]                req_mip_count_override;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [PITCH_W-1:0]              rsp_row_pitch;
   logic [DIM_W-1:0]                rsp_row_count;
   logic [LPITCH_W-1:0]             rsp_level_pitch;
   logic [LPITCH_W-1:0]             rsp_level_offset;
   logic [LPITCH_W-1:0]             rsp_slice_pitch;
   logic [LVL_W-1:0]                rsp_chain_length;
   logic [LPITCH_W+SLICE_BITS-1:0]  rsp_buffer_offset;
   logic [STATUS_W-1:0]             rsp_status;

   int pending_layouts;
   int mismatch_count;
   int sent_count;
   int idle_cycles;

   texture_mip_layout_offset #(.SLICE_BITS(SLICE_BITS)) dut (.*);

   tmlo_layout_checker #(.SLICE_BITS(SLICE_BITS)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_req(input logic [FMT_W-1:0] fmt, input logic [DIM_W-1:0] w,
                           input logic [DIM_W-1:0] h, input logic [LVL_W-1:0] lvl,
                           input logic [SLICE_BITS-1:0] slice,
                           input logic [LVL_W-1:0] ovr);
      req_valid              <= 1'b1;
      req_format_code        <= fmt;
      req_base_width         <= w;
      req_base_height        <= h;
      req_mip_level          <= lvl;
      req_array_slice        <= slice;
      req_mip_count_override <= ovr;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic drain_layouts();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_layouts != 0) @(negedge clock);
   endtask

   // response side: random stall patterns plus one long hold-off
   initial begin
      int mode;
      int span;
      bit held_off;
      mode = 0;
      span = 0;
      held_off = 1'b0;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!held_off && sent_count >= 300) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (80) @(negedge clock);
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 2);
               span = $urandom_range(5, 60);
            end
            span--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      int burst_left;
      int kind;
      int wl;
      int hl;
      int chain;
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      reset = 1'b1;
      req_valid = 1'b0;
      req_format_code = '0;
      req_base_width = '0;
      req_base_height = '0;
      req_mip_level = '0;
      req_array_slice = '0;
      req_mip_count_override = '0;
      sent_count = 0;
      idle_cycles = 0;
      burst_left = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // unknown formats, unknown wins over a bad base
      send_req(7'd0,   15'd16,    15'd16,    4'd0,  '0,            4'd0);
      send_req(7'd102, 15'd16,    15'd16,    4'd0,  '0,            4'd0);
      send_req(7'd127, 15'd32767, 15'd32767, 4'd15, '1,            4'd15);
      // bad base: zero, not a power of two, all ones
      send_req(7'd1,   15'd0,     15'd8,     4'd0,  '0,            4'd0);
      send_req(7'd1,   15'd8,     15'd12,    4'd0,  '0,            4'd0);
      send_req(7'd23,  15'd32767, 15'd1,     4'd0,  '0,            4'd0);
      // level beyond the chain
      send_req(7'd23,  15'd8,     15'd4,     4'd4,  '0,            4'd0);
      send_req(7'd1,   15'd16384, 15'd16384, 4'd15, '0,            4'd0);
      // largest sizes and slice
      send_req(7'd1,   15'd16384, 15'd16384, 4'd14, '1,            4'd0);
      send_req(7'd1,   15'd16384, 15'd16384, 4'd0,  '1,            4'd0);
      send_req(7'd99,  15'd16384, 15'd16384, 4'd0,  '1,            4'd15);
      // override past the chain, and one below it
      send_req(7'd23,  15'd1,     15'd1,     4'd0,  11'd5,         4'd15);
      send_req(7'd70,  15'd1,     15'd1,     4'd0,  11'd3,         4'd15);
      send_req(7'd48,  15'd256,   15'd64,    4'd3,  11'd1024,      4'd1);
      // block-compressed tails and odd element sizes
      send_req(7'd73,  15'd16384, 15'd2,     4'd13, 11'd7,         4'd0);
      send_req(7'd84,  15'd4096,  15'd1,     4'd12, 11'd2,         4'd0);
      send_req(7'd5,   15'd1,     15'd2,     4'd0,  11'd1,         4'd0);
      send_req(7'd8,   15'd2,     15'd1,     4'd1,  11'd1,         4'd0);
      send_req(7'd101, 15'd2,     15'd2,     4'd0,  11'd9,         4'd0);
      send_req(7'd100, 15'd1,     15'd16384, 4'd14, 11'd1,         4'd0);
      send_req(7'd60,  15'd2,     15'd8,     4'd1,  11'd1365,      4'd2);
      drain_layouts();

      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (n == RANDOM_REQS / 2) begin
            drain_layouts();
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(negedge clock);
            end
         end
         burst_left--;
         kind = $urandom_range(0, 99);
         wl = $urandom_range(0, MAX_DIM_LOG2);
         hl = ($urandom_range(0, 3) == 0) ? wl : $urandom_range(0, MAX_DIM_LOG2);
         w = DIM_W'(1) << wl;
         h = DIM_W'(1) << hl;
         chain = ((wl > hl) ? wl : hl) + 1;
         if (kind < 85) begin
            send_req(FMT_W'($urandom_range(1, FORMAT_COUNT - 1)), w, h,
                     LVL_W'($urandom_range(0, chain - 1)),
                     SLICE_BITS'($urandom_range(0, (1 << SLICE_BITS) - 1)),
                     ($urandom_range(0, 1) == 0) ? '0 : LVL_W'($urandom_range(1, 15)));
         end else if (kind < 90) begin
            send_req(FMT_W'($urandom_range(1, FORMAT_COUNT - 1)), w, h,
                     LVL_W'($urandom_range(0, 15)),
                     SLICE_BITS'($urandom), LVL_W'($urandom));
         end else if (kind < 95) begin
            send_req(($urandom_range(0, 1) == 0) ? '0
                        : FMT_W'($urandom_range(FORMAT_COUNT, (1 << FMT_W) - 1)),
                     w, h, LVL_W'($urandom), SLICE_BITS'($urandom), LVL_W'($urandom));
         end else begin
            send_req(FMT_W'($urandom), DIM_W'($urandom), DIM_W'($urandom),
                     LVL_W'($urandom), SLICE_BITS'($urandom), LVL_W'($urandom));
         end
      end

      drain_layouts();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
